/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define EFSA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define EFSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/efsa_pkg.sv */
// Package with widths, register codes, reset values and shared types of the block.
`timescale 1ns / 1ps
package efsa_pkg;

    localparam int WINDOWS_DEF = 8;
    localparam int IDX_W       = 7;     // wide enough for the largest window count

    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int SVCM_W  = 10;
    localparam int WIDX_W  = 3;
    localparam int TIME_W  = 32;
    localparam int SUM_W   = 48;
    localparam int CNT_W   = 20;
    localparam int ARR_W   = 17;        // hour*3600 + minute*60 + second fits
    localparam int SVC_W   = 16;        // service minutes times sixty fits

    localparam int WIN_W   = 4;
    localparam int OPEN_W  = 17;
    localparam int CLOSE_W = 5;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOWS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_SECONDS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_HOUR     = 2'd2;

    localparam int SECS_PER_MIN  = 60;
    localparam int SECS_PER_HOUR = 60 * 60;

    localparam logic [WIN_W-1:0]   WIN_RESET   = 4'd8;
    localparam logic [OPEN_W-1:0]  OPEN_RESET  = OPEN_W'(8 * SECS_PER_HOUR);
    localparam logic [CLOSE_W-1:0] CLOSE_RESET = 5'd17;

    // Running minimum handed from cell to cell.
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] free;
        logic [IDX_W-1:0]  idx;
    } t_cand;

    // Broadcast update of one window's free time.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] value;
    } t_wr;

endpackage

/* rtl/efsa_if.sv */
// Interfaces for the customer, result and configuration channels.
`timescale 1ns / 1ps
interface efsa_item_if import efsa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [HOUR_W-1:0] arrive_hour;
    logic [MIN_W-1:0]  arrive_minute;
    logic [SEC_W-1:0]  arrive_second;
    logic [SVCM_W-1:0] service_minutes;

    modport source (output valid, arrive_hour, arrive_minute, arrive_second,
                    service_minutes, input ready);
    modport sink   (input valid, arrive_hour, arrive_minute, arrive_second,
                    service_minutes, output ready);
endinterface

interface efsa_result_if import efsa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              accepted;
    logic [WIDX_W-1:0] window_index;
    logic [TIME_W-1:0] start_seconds;
    logic [TIME_W-1:0] wait_seconds;
    logic [SUM_W-1:0]  total_wait;
    logic [CNT_W-1:0]  served_count;

    modport source (output valid, accepted, window_index, start_seconds, wait_seconds,
                    total_wait, served_count, input ready);
    modport sink   (input valid, accepted, window_index, start_seconds, wait_seconds,
                    total_wait, served_count, output ready);
endinterface

interface efsa_cfg_if import efsa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

/* rtl/earliest_free_server_assign.sv */
// Top level: earliest-free window assignment over a row of window cells.
// A customer is captured, converted to seconds, searched for by the minimum token
// walking one cell per cycle, and written to the result register; a rejected customer
// skips the search. A new customer is taken only once the last result is loaded.
// Reset (synchronous, active low): every window free at 08:00:00, sums cleared.
`timescale 1ns / 1ps
module earliest_free_server_assign import efsa_pkg::*; #(
    parameter int WINDOWS = WINDOWS_DEF
) (
    input logic           i_clk,
    input logic           i_rst_n,
    efsa_item_if.sink     i_item,
    efsa_cfg_if.sink      i_cfg,
    efsa_result_if.source o_result
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CALC   = 4'b0010,
        S_SEARCH = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // captured customer
    logic [HOUR_W-1:0] r_hour;
    logic [MIN_W-1:0]  r_minute;
    logic [SEC_W-1:0]  r_second;
    logic [SVCM_W-1:0] r_svc_min;
    logic              r_rej;
    logic [ARR_W-1:0]  r_arrival;
    logic [SVC_W-1:0]  r_svc60;

    // outcome of the search
    logic [IDX_W-1:0]  r_best_idx;
    logic [TIME_W-1:0] r_start;
    logic [TIME_W-1:0] r_wait;

    // configuration and running totals
    logic [WIN_W-1:0]   r_windows;
    logic [CLOSE_W-1:0] r_close;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    // result register
    logic              r_out_valid;
    logic              r_out_accepted;
    logic [WIDX_W-1:0] r_out_widx;
    logic [TIME_W-1:0] r_out_start;
    logic [TIME_W-1:0] r_out_wait;
    logic [SUM_W-1:0]  r_out_total;
    logic [CNT_W-1:0]  r_out_count;

    logic               w_item_xfer;
    logic               w_cfg_xfer;
    logic               w_reload;
    logic [OPEN_W-1:0]  w_open;
    logic               w_slot_free;
    logic               w_load;
    logic [TIME_W-1:0]  w_arr32;
    logic [TIME_W-1:0]  w_start;
    logic [TIME_W:0]    w_end;
    logic [TIME_W-1:0]  w_end_sat;
    logic [SUM_W:0]     w_sum_add;
    logic [WINDOWS-1:0] w_en;
    t_wr                w_wr;
    t_cand              w_chain [0:WINDOWS];

    // ---------------------------------------------------------------
    // Handshakes. Configuration is always taken; a customer only when
    // idle. The result register parts the sides, so a finished result
    // may wait while the next customer is already in work.
    // ---------------------------------------------------------------
    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign w_item_xfer  = i_item.valid && i_item.ready;
    assign w_cfg_xfer   = i_cfg.valid && i_cfg.ready;

    // Writing the opening time reloads every window at once.
    assign w_reload = w_cfg_xfer && (i_cfg.reg_index == REG_OPEN_SECONDS);
    assign w_open   = i_cfg.wdata[OPEN_W-1:0];

    assign w_slot_free = !r_out_valid || o_result.ready;
    assign w_load      = (r_state == S_FINISH) && w_slot_free;

    // ---------------------------------------------------------------
    // Window row. A zero window count still enables window 0; counts
    // beyond the row are clipped simply because no cell lies there.
    // ---------------------------------------------------------------
    assign w_chain[0] = '{valid: (r_state == S_CALC) && !r_rej,
                          free:  {TIME_W{1'b1}},
                          idx:   '0};

    generate
        for (genvar g = 0; g < WINDOWS; g++) begin : g_cell
            assign w_en[g] = (g == 0) || ((IDX_W + 1)'(r_windows) > (IDX_W + 1)'(g));

            efsa_cell #(
                .CELL_IDX (g)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_en     (w_en[g]),
                .i_reload (w_reload),
                .i_open   (w_open),
                .i_wr     (w_wr),
                .i_cand   (w_chain[g]),
                .o_cand   (w_chain[g + 1])
            );
        end
    endgenerate

    // ---------------------------------------------------------------
    // Datapath. Start is the later of arrival and the earliest free
    // time; the new free time and the wait sum saturate.
    // ---------------------------------------------------------------
    assign w_arr32 = TIME_W'(r_arrival);
    assign w_start = (w_chain[WINDOWS].free > w_arr32) ? w_chain[WINDOWS].free : w_arr32;

    assign w_end     = {1'b0, r_start} + (TIME_W + 1)'(r_svc60);
    assign w_end_sat = w_end[TIME_W] ? {TIME_W{1'b1}} : w_end[TIME_W-1:0];

    assign w_sum_add = {1'b0, r_sum} + (SUM_W + 1)'(r_wait);
    assign n_sum     = w_sum_add[SUM_W] ? {SUM_W{1'b1}} : w_sum_add[SUM_W-1:0];
    assign n_cnt     = (r_cnt == {CNT_W{1'b1}}) ? r_cnt : r_cnt + CNT_W'(1);

    assign w_wr = '{en: w_load && !r_rej, idx: r_best_idx, value: w_end_sat};

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_item_xfer) n_state = S_CALC;
            end
            S_CALC: begin
                n_state = r_rej ? S_FINISH : S_SEARCH;
            end
            S_SEARCH: begin
                if (w_chain[WINDOWS].valid) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (w_slot_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_windows   <= WIN_RESET;
            r_close     <= CLOSE_RESET;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_cfg_xfer && (i_cfg.reg_index == REG_WINDOWS_IN_USE)) begin
                r_windows <= i_cfg.wdata[WIN_W-1:0];
            end
            if (w_cfg_xfer && (i_cfg.reg_index == REG_CLOSE_HOUR)) begin
                r_close <= i_cfg.wdata[CLOSE_W-1:0];
            end

            // capture the customer and decide rejection up front
            if (w_item_xfer) begin
                r_hour    <= i_item.arrive_hour;
                r_minute  <= i_item.arrive_minute;
                r_second  <= i_item.arrive_second;
                r_svc_min <= i_item.service_minutes;
                r_rej     <= (i_item.arrive_hour >= r_close);
            end

            // convert to seconds
            if (r_state == S_CALC) begin
                r_arrival <= ARR_W'(r_hour) * ARR_W'(SECS_PER_HOUR)
                           + ARR_W'(r_minute) * ARR_W'(SECS_PER_MIN)
                           + ARR_W'(r_second);
                r_svc60   <= SVC_W'(r_svc_min) * SVC_W'(SECS_PER_MIN);
            end

            // hold the winner when the token leaves the last cell
            if ((r_state == S_SEARCH) && w_chain[WINDOWS].valid) begin
                r_best_idx <= w_chain[WINDOWS].idx;
                r_start    <= w_start;
                r_wait     <= w_start - w_arr32;
            end

            // load the result; advance totals only for a served customer
            if (w_load) begin
                r_out_valid <= 1'b1;
                if (r_rej) begin
                    r_out_accepted <= 1'b0;
                    r_out_widx     <= '0;
                    r_out_start    <= '0;
                    r_out_wait     <= '0;
                    r_out_total    <= r_sum;
                    r_out_count    <= r_cnt;
                end else begin
                    r_out_accepted <= 1'b1;
                    r_out_widx     <= r_best_idx[WIDX_W-1:0];
                    r_out_start    <= r_start;
                    r_out_wait     <= r_wait;
                    r_out_total    <= n_sum;
                    r_out_count    <= n_cnt;
                    r_sum          <= n_sum;
                    r_cnt          <= n_cnt;
                end
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.accepted      = r_out_accepted;
    assign o_result.window_index  = r_out_widx;
    assign o_result.start_seconds = r_out_start;
    assign o_result.wait_seconds  = r_out_wait;
    assign o_result.total_wait    = r_out_total;
    assign o_result.served_count  = r_out_count;

endmodule

/* rtl/efsa_cell.sv */
// One window cell: holds its free time and folds it into the passing minimum.
`timescale 1ns / 1ps
module efsa_cell import efsa_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_reload,
    input  logic [OPEN_W-1:0] i_open,
    input  t_wr               i_wr,
    input  t_cand             i_cand,
    output t_cand             o_cand
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [TIME_W-1:0] r_free;
    t_cand             r_cand;
    t_cand             n_cand;
    logic              w_take;

    // strict less keeps the lower index on a tie
    assign w_take = i_en && (r_free < i_cand.free);

    always_comb begin
        n_cand.valid = i_cand.valid;
        n_cand.free  = w_take ? r_free : i_cand.free;
        n_cand.idx   = w_take ? MY_IDX : i_cand.idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free       <= TIME_W'(OPEN_RESET);
            r_cand.valid <= 1'b0;
        end else begin
            if (i_reload) begin
                r_free <= TIME_W'(i_open);
            end else if (i_wr.en && (i_wr.idx == MY_IDX)) begin
                r_free <= i_wr.value;
            end
            r_cand <= n_cand;
        end
    end

    assign o_cand = r_cand;

endmodule

/* rtl/efsa_checker.sv */
// Port-level checker for the block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module efsa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_accepted,
    input logic [2:0]  i_out_window_index,
    input logic [31:0] i_out_start_seconds,
    input logic [31:0] i_out_wait_seconds,
    input logic [47:0] i_out_total_wait,
    input logic [19:0] i_out_served_count
);

    `EFSA_ASSERT_IMPLY(a_reject_zero, i_clk, i_rst_n, i_out_valid && !i_out_accepted, (i_out_window_index == 3'd0) && (i_out_start_seconds == 32'd0) && (i_out_wait_seconds == 32'd0))
    `EFSA_ASSERT_IMPLY(a_wait_le_start, i_clk, i_rst_n, i_out_valid && i_out_accepted, i_out_start_seconds >= i_out_wait_seconds)
    `EFSA_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `EFSA_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable({i_out_accepted, i_out_window_index, i_out_start_seconds, i_out_wait_seconds, i_out_total_wait, i_out_served_count}))

endmodule

bind earliest_free_server_assign efsa_checker u_efsa_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_item.valid),
    .i_in_ready          (i_item.ready),
    .i_out_valid         (o_result.valid),
    .i_out_ready         (o_result.ready),
    .i_out_accepted      (o_result.accepted),
    .i_out_window_index  (o_result.window_index),
    .i_out_start_seconds (o_result.start_seconds),
    .i_out_wait_seconds  (o_result.wait_seconds),
    .i_out_total_wait    (o_result.total_wait),
    .i_out_served_count  (o_result.served_count)
);
